[design/remote_response_frame_parser_assert.svh]
// assertion macros for the frame parser core
`ifndef REMOTE_RESPONSE_FRAME_PARSER_ASSERT_SVH
`define REMOTE_RESPONSE_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RRFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rrfp_pkg.sv]
// types and constants for the remote response frame parser
package rrfp_pkg;

    localparam int unsigned POS_W = 7;

    localparam logic [7:0] DELIM          = 8'h7E;
    localparam logic [7:0] SUM_OK         = 8'hFF;
    localparam logic [7:0] STATUS_CODE_OK = 8'h00;
    localparam logic [7:0] STATUS_CODE_ERR = 8'h01;

    localparam logic [15:0] MIN_LEN = 16'd15;

    localparam logic [POS_W-1:0] POS_LEN_HI     = 7'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO     = 7'd2;
    localparam logic [POS_W-1:0] POS_BODY_START = 7'd3;
    localparam logic [POS_W-1:0] POS_ADDR_FIRST = 7'd5;
    localparam logic [POS_W-1:0] POS_ADDR_LAST  = 7'd12;
    localparam logic [POS_W-1:0] POS_CMD_HI     = 7'd15;
    localparam logic [POS_W-1:0] POS_CMD_LO     = 7'd16;
    localparam logic [POS_W-1:0] POS_STATUS     = 7'd17;
    localparam logic [POS_W-1:0] POS_DATA       = 7'd18;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ERROR   = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_class_t;

    typedef struct packed {
        logic [7:0]    data_byte;
        logic          last;
        logic [15:0]   frame_length;
        logic [63:0]   source_address;
        logic [15:0]   command_code;
        status_class_t status_class;
        logic          checksum_ok;
        logic          length_error;
    } result_t;

    function automatic status_class_t classify_status(input logic [7:0] status);
        status_class_t cls;
        if (status == STATUS_CODE_OK)
        begin
            cls = STATUS_OK;
        end
        else if (status == STATUS_CODE_ERR)
        begin
            cls = STATUS_ERROR;
        end
        else
        begin
            cls = STATUS_UNKNOWN;
        end
        return cls;
    endfunction

endpackage

[design/rrfp_in_stage.sv]
// input register stage holding one received byte
module rrfp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       advance,
    output logic       s1_valid,
    output logic [7:0] s1_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready = !valid_reg || advance;
    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

[design/rrfp_core.sv]
// frame state and per-byte parse logic
`include "remote_response_frame_parser_assert.svh"

module rrfp_core #(
    parameter int unsigned MAX_FRAME_BYTES = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       byte_in,
    output logic             res_valid,
    output rrfp_pkg::result_t res
);

    localparam logic [15:0] LEN_MAX = 16'(MAX_FRAME_BYTES - 4);

    logic                      in_frame_reg;
    logic                      in_frame_next;
    logic [rrfp_pkg::POS_W-1:0] pos_reg;
    logic [rrfp_pkg::POS_W-1:0] pos_next;
    logic [15:0]               length_reg;
    logic [15:0]               length_next;
    logic [7:0]                sum_reg;
    logic [7:0]                sum_next;
    logic [63:0]               addr_reg;
    logic [63:0]               addr_next;
    logic [15:0]               cmd_reg;
    logic [15:0]               cmd_next;
    logic [7:0]                status_reg;
    logic [7:0]                status_next;

    logic [15:0] len_full;
    logic        len_bad;
    logic [7:0]  sum_new;
    logic        at_checksum;

    assign len_full    = {length_reg[15:8], byte_in};
    assign len_bad     = (len_full < rrfp_pkg::MIN_LEN) || (len_full > LEN_MAX);
    assign sum_new     = sum_reg + byte_in;
    // length is at most MAX_FRAME_BYTES - 4 (124 by default) once past the header check
    assign at_checksum = ({1'b0, pos_reg} == (length_reg[7:0] + 8'd3));

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        length_next   = length_reg;
        sum_next      = sum_reg;
        addr_next     = addr_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (step)
        begin
            if (!in_frame_reg)
            begin
                if (byte_in == rrfp_pkg::DELIM)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = rrfp_pkg::POS_LEN_HI;
                    length_next   = '0;
                    sum_next      = '0;
                    addr_next     = '0;
                    cmd_next      = '0;
                    status_next   = '0;
                end
            end
            else if (pos_reg == rrfp_pkg::POS_LEN_HI)
            begin
                length_next = {byte_in, 8'h00};
                pos_next    = rrfp_pkg::POS_LEN_LO;
            end
            else if (pos_reg == rrfp_pkg::POS_LEN_LO)
            begin
                if (len_bad)
                begin
                    // length summary, then back to hunting
                    res_valid          = 1'b1;
                    res.last           = 1'b1;
                    res.frame_length   = len_full;
                    res.length_error   = 1'b1;
                    in_frame_next      = 1'b0;
                    pos_next           = '0;
                    length_next        = '0;
                    sum_next           = '0;
                    addr_next          = '0;
                    cmd_next           = '0;
                    status_next        = '0;
                end
                else
                begin
                    length_next = len_full;
                    pos_next    = rrfp_pkg::POS_BODY_START;
                end
            end
            else
            begin
                sum_next = sum_new;
                if (at_checksum)
                begin
                    res_valid          = 1'b1;
                    res.last           = 1'b1;
                    res.frame_length   = length_reg;
                    res.source_address = addr_reg;
                    res.command_code   = cmd_reg;
                    res.status_class   = rrfp_pkg::classify_status(status_reg);
                    res.checksum_ok    = (sum_new == rrfp_pkg::SUM_OK);
                    in_frame_next      = 1'b0;
                    pos_next           = '0;
                    length_next        = '0;
                    sum_next           = '0;
                    addr_next          = '0;
                    cmd_next           = '0;
                    status_next        = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    if ((pos_reg >= rrfp_pkg::POS_ADDR_FIRST) &&
                        (pos_reg <= rrfp_pkg::POS_ADDR_LAST))
                    begin
                        addr_next = {addr_reg[55:0], byte_in};
                    end
                    else if (pos_reg == rrfp_pkg::POS_CMD_HI)
                    begin
                        cmd_next = {byte_in, 8'h00};
                    end
                    else if (pos_reg == rrfp_pkg::POS_CMD_LO)
                    begin
                        cmd_next = {cmd_reg[15:8], byte_in};
                    end
                    else if (pos_reg == rrfp_pkg::POS_STATUS)
                    begin
                        status_next = byte_in;
                    end
                    else if (pos_reg >= rrfp_pkg::POS_DATA)
                    begin
                        res_valid     = 1'b1;
                        res.data_byte = byte_in;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            length_reg   <= '0;
            sum_reg      <= '0;
            addr_reg     <= '0;
            cmd_reg      <= '0;
            status_reg   <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            length_reg   <= length_next;
            sum_reg      <= sum_next;
            addr_reg     <= addr_next;
            cmd_reg      <= cmd_next;
            status_reg   <= status_next;
        end
    end

    `RRFP_ASSERT_IMPL(a_hunt_pos_zero, clk, rst_n, !in_frame_reg, pos_reg == '0,
        "position not cleared while hunting")
    `RRFP_ASSERT_IMPL(a_summary_no_data, clk, rst_n, res_valid && res.last,
        res.data_byte == 8'h00, "summary carries a data byte")
    `RRFP_ASSERT_IMPL(a_len_err_clean, clk, rst_n, res_valid && res.length_error,
        res.last && (res.source_address == 64'h0) && !res.checksum_ok,
        "length error summary has stray fields")
    `RRFP_ASSERT_NEXT(a_summary_ends_frame, clk, rst_n, step && res_valid && res.last,
        !in_frame_reg, "frame still open after summary")

endmodule

[design/rrfp_out_stage.sv]
// result register between the parser and the output channel
module rrfp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rrfp_pkg::result_t res_in,
    output logic              slot_free,
    output logic              out_valid,
    input  logic              out_ready,
    output rrfp_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    rrfp_pkg::result_t res_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

[design/remote_response_frame_parser.sv]
// top level of the remote command response frame parser
// a byte accepted into the input register is parsed into the result register once the result slot is free
// throughput: one byte per cycle while the output channel is ready; the combinational byte parse and 8-bit sum allow it
// a byte that yields no transaction still moves through the input register
// reset: rst_n asynchronous active low, parser hunts for the delimiter, both stages empty
module remote_response_frame_parser #(
    parameter int unsigned MAX_FRAME_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [15:0] frame_length,
    output logic [63:0] source_address,
    output logic [15:0] command_code,
    output logic [1:0]  status_class,
    output logic        checksum_ok,
    output logic        length_error
);

    // stage one holds the received byte
    logic       s1_valid;
    logic [7:0] s1_byte;

    // the byte in stage one is parsed when the result slot can take its outcome
    logic slot_free;
    logic advance;

    logic              res_valid;
    rrfp_pkg::result_t res;
    rrfp_pkg::result_t res_out;

    assign advance = s1_valid && slot_free;

    rrfp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    // frame position, header capture and running checksum
    rrfp_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_in   (s1_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // only data bytes and summaries become output transactions
    rrfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res_in    (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign data_byte      = res_out.data_byte;
    assign last           = res_out.last;
    assign frame_length   = res_out.frame_length;
    assign source_address = res_out.source_address;
    assign command_code   = res_out.command_code;
    assign status_class   = res_out.status_class;
    assign checksum_ok    = res_out.checksum_ok;
    assign length_error   = res_out.length_error;

endmodule

[tb/remote_response_frame_parser_test.sv]
// self-checking testbench for the remote response frame parser
`timescale 1ns / 1ps

module remote_response_frame_parser_test;

    localparam int unsigned MAX_FRAME  = 128;
    localparam logic [15:0] LEN_LIMIT  = 16'(MAX_FRAME - 4);
    localparam int unsigned HALF_NS    = 4;
    localparam int unsigned RESET_CYC  = 11;
    localparam int unsigned ITEM_GOAL  = 550;
    // no idling once this many bytes are in
    localparam int unsigned STEADY_AT  = 470;
    // the block registers input and output, so the bench waits for it to drain
    localparam int unsigned DRAIN_CYC  = 8;
    localparam int unsigned TIMEOUT_NS = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [7:0]  rx_byte;
    logic        in_valid;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] frame_length;
    logic [63:0] source_address;
    logic [15:0] command_code;
    logic [1:0]  status_class;
    logic        checksum_ok;
    logic        length_error;

    // shadow parser: tracks the frame as bytes are accepted and queues the
    // transactions the block should produce
    class frame_scoreboard;
        logic              in_frame;
        logic [6:0]        pos;
        logic [15:0]       len;
        logic [7:0]        sum;
        logic [63:0]       addr;
        logic [15:0]       cmd;
        logic [7:0]        status;
        rrfp_pkg::result_t expected_q[$];
        int                errors;

        function new();
            in_frame = 1'b0;
            clear_frame();
            errors = 0;
        endfunction

        function void clear_frame();
            pos    = '0;
            len    = '0;
            sum    = '0;
            addr   = '0;
            cmd    = '0;
            status = '0;
        endfunction

        function void enqueue(input rrfp_pkg::result_t item);
            expected_q = {expected_q, item};
        endfunction

        function void note_byte(input logic [7:0] b);
            rrfp_pkg::result_t item;
            logic [6:0]        here;
            item = '0;
            here = pos;
            // hunting: everything but the delimiter is dropped
            if (!in_frame)
            begin
                if (b == rrfp_pkg::DELIM)
                begin
                    clear_frame();
                    in_frame = 1'b1;
                    pos = rrfp_pkg::POS_LEN_HI;
                end
                return;
            end
            if (here == rrfp_pkg::POS_LEN_HI)
            begin
                len = {b, 8'h00};
                pos = rrfp_pkg::POS_LEN_LO;
                return;
            end
            if (here == rrfp_pkg::POS_LEN_LO)
            begin
                len = {len[15:8], b};
                // short or oversized frame gives an immediate error summary
                if (len < rrfp_pkg::MIN_LEN || len > LEN_LIMIT)
                begin
                    item.last         = 1'b1;
                    item.frame_length = len;
                    item.length_error = 1'b1;
                    enqueue(item);
                    in_frame = 1'b0;
                    clear_frame();
                    return;
                end
                pos = rrfp_pkg::POS_BODY_START;
                return;
            end
            sum = sum + b;
            // checksum byte closes the frame
            if ({9'd0, here} == len + 16'd3)
            begin
                item.last           = 1'b1;
                item.frame_length   = len;
                item.source_address = addr;
                item.command_code   = cmd;
                item.status_class   =
                    (status == rrfp_pkg::STATUS_CODE_OK)  ? rrfp_pkg::STATUS_OK :
                    (status == rrfp_pkg::STATUS_CODE_ERR) ? rrfp_pkg::STATUS_ERROR :
                                                            rrfp_pkg::STATUS_UNKNOWN;
                item.checksum_ok    = (sum == rrfp_pkg::SUM_OK);
                enqueue(item);
                in_frame = 1'b0;
                clear_frame();
                return;
            end
            pos = here + 7'd1;
            if (here >= rrfp_pkg::POS_ADDR_FIRST && here <= rrfp_pkg::POS_ADDR_LAST)
            begin
                addr = {addr[55:0], b};
            end
            else if (here == rrfp_pkg::POS_CMD_HI)
            begin
                cmd = {b, 8'h00};
            end
            else if (here == rrfp_pkg::POS_CMD_LO)
            begin
                cmd = {cmd[15:8], b};
            end
            else if (here == rrfp_pkg::POS_STATUS)
            begin
                status = b;
            end
            else if (here >= rrfp_pkg::POS_DATA)
            begin
                item.data_byte = b;
                enqueue(item);
            end
        endfunction

        function void compare_field(input string name, input logic [63:0] want,
                                    input logic [63:0] seen);
            if (seen !== want)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(input rrfp_pkg::result_t got);
            rrfp_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
            compare_field("last", 64'(want.last), 64'(got.last));
            compare_field("frame_length", 64'(want.frame_length), 64'(got.frame_length));
            compare_field("source_address", want.source_address, got.source_address);
            compare_field("command_code", 64'(want.command_code), 64'(got.command_code));
            compare_field("status_class", 64'(want.status_class), 64'(got.status_class));
            compare_field("checksum_ok", 64'(want.checksum_ok), 64'(got.checksum_ok));
            compare_field("length_error", 64'(want.length_error), 64'(got.length_error));
        endfunction
    endclass

    frame_scoreboard board;
    int unsigned     sent_count = 0;
    bit              steady = 1'b0;

    remote_response_frame_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_byte      (data_byte),
        .last           (last),
        .frame_length   (frame_length),
        .source_address (source_address),
        .command_code   (command_code),
        .status_class   (status_class),
        .checksum_ok    (checksum_ok),
        .length_error   (length_error)
    );

    always
    begin
        #(HALF_NS) clk = 1'b1;
        #(HALF_NS) clk = 1'b0;
    end

    // present one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        // random idle burst ahead of the byte
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_byte(b);
        sent_count++;
        if (sent_count >= STEADY_AT)
        begin
            steady = 1'b1;
        end
    endtask

    // delimiter plus a bad length field
    task automatic send_length_error(input logic [15:0] len);
        send_byte(rrfp_pkg::DELIM);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // build a whole frame with random content and send its first keep bytes
    task automatic send_frame(input int unsigned len, input logic [7:0] status,
                              input bit good_sum, input int unsigned keep);
        logic [7:0]  frame[$];
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned i;
        frame = {};
        sum = '0;
        frame = {frame, rrfp_pkg::DELIM};
        frame = {frame, len[15:8]};
        frame = {frame, len[7:0]};
        for (i = 3; i < len + 3; i++)
        begin
            if (i == rrfp_pkg::POS_STATUS)
            begin
                b = status;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                // delimiter value inside a frame is plain data
                b = rrfp_pkg::DELIM;
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
            end
            frame = {frame, b};
            sum = sum + b;
        end
        b = rrfp_pkg::SUM_OK - sum;
        if (!good_sum)
        begin
            b = b + 8'($urandom_range(1, 255));
        end
        frame = {frame, b};
        for (i = 0; i < keep && i < frame.size(); i++)
        begin
            send_byte(frame[i]);
        end
    endtask

    function automatic logic [7:0] pick_status();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return rrfp_pkg::STATUS_CODE_OK;
        end
        else if (r < 7)
        begin
            return rrfp_pkg::STATUS_CODE_ERR;
        end
        return 8'($urandom_range(2, 255));
    endfunction

    // receiver side: random stall bursts, none at the end
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        rrfp_pkg::result_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.data_byte      = data_byte;
            got.last           = last;
            got.frame_length   = frame_length;
            got.source_address = source_address;
            got.command_code   = command_code;
            got.status_class   = rrfp_pkg::status_class_t'(status_class);
            got.checksum_ok    = checksum_ok;
            got.length_error   = length_error;
            board.check_result(got);
        end
    end

    // main stimulus
    initial
    begin
        int unsigned pick;
        int unsigned len;
        board = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: junk while hunting, length errors at both edges, empty data frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_length_error(rrfp_pkg::MIN_LEN - 16'd1);
        send_length_error(LEN_LIMIT + 16'd1);
        send_length_error(16'h0000);
        send_length_error(16'hFFFF);
        send_frame(32'(rrfp_pkg::MIN_LEN), rrfp_pkg::STATUS_CODE_ERR, 1'b1, 1000);

        // random: mostly well-formed frames, some noise and broken frames
        while (sent_count < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                len = $urandom_range(0, 19);
                if (len == 0)
                begin
                    len = 32'(LEN_LIMIT);
                end
                else if (len == 1)
                begin
                    len = $urandom_range(60, LEN_LIMIT - 1);
                end
                else
                begin
                    len = $urandom_range(rrfp_pkg::MIN_LEN, 30);
                end
                send_frame(len, pick_status(), $urandom_range(0, 3) != 0, 1000);
            end
            else if (pick == 7)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_length_error(16'($urandom_range(0, rrfp_pkg::MIN_LEN - 1)));
                end
                else
                begin
                    send_length_error(16'($urandom_range(LEN_LIMIT + 1, 65535)));
                end
            end
            else if (pick == 8)
            begin
                // line noise between frames
                repeat ($urandom_range(1, 4))
                begin
                    len = $urandom_range(0, 255);
                    send_byte((len == rrfp_pkg::DELIM) ? 8'h7D : 8'(len));
                end
            end
            else
            begin
                // frame cut short; the next delimiter lands inside it
                send_frame($urandom_range(rrfp_pkg::MIN_LEN, 30), pick_status(), 1'b1,
                           $urandom_range(1, 20));
            end
        end
        in_valid <= 1'b0;

        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (board.errors == 0 && board.expected_q.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
